/* rtl/prr_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// prr_pkg
// Shared types and constants of the pixel range rescaler.
// ----------------------------------------------------------------------------
package prr_pkg;

   // opcodes of an input word
   localparam logic OPC_MEASURE = 1'b0;
   localparam logic OPC_APPLY   = 1'b1;

   // mode register codes
   localparam logic MODE_RANGE = 1'b0;
   localparam logic MODE_GAIN  = 1'b1;

   // register map, index = paddr[3:2]
   localparam int          CFG_ADDR_BITS = 4;
   localparam logic [1:0]  REG_MODE      = 2'd0;
   localparam logic [1:0]  REG_OUT_MIN   = 2'd1;
   localparam logic [1:0]  REG_OUT_MAX   = 2'd2;
   localparam logic [1:0]  REG_GAIN      = 2'd3;

   localparam int          RANGE_BITS    = 15;
   localparam int          GAIN_BITS     = 32;
   localparam int          FRAC_BITS     = 16;
   localparam logic [RANGE_BITS-1:0] OUT_MIN_RST = 15'd0;
   localparam logic [RANGE_BITS-1:0] OUT_MAX_RST = 15'd32767;
   localparam logic [GAIN_BITS-1:0]  GAIN_RST    = 32'h0001_0000;
   localparam logic [FRAC_BITS-1:0]  ROUND_HALF  = 16'h8000;

   typedef struct packed {
      logic                  mode;
      logic [RANGE_BITS-1:0] out_min;
      logic [RANGE_BITS-1:0] out_max;
      logic [GAIN_BITS-1:0]  gain;
   } cfg_type;

   // how the back end treats an apply word
   localparam int CLS_BITS = 2;
   typedef enum logic [CLS_BITS-1:0] {
      CLS_ZERO  = 2'd0,   // non-positive pixel in range mode
      CLS_OMIN  = 2'd1,   // empty or inverted range
      CLS_RANGE = 2'd2,   // linear map with division
      CLS_GAIN  = 2'd3    // multiply by gain
   } cls_type;

endpackage
`default_nettype wire

/* rtl/prr_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// prr_if
// Valid/ready channels for input words and result words.
// ----------------------------------------------------------------------------
interface prr_req_if #(parameter int PIXEL_BITS = 16);
   logic                         valid;
   logic                         ready;
   logic                         opcode;
   logic                         first_of_group;
   logic signed [PIXEL_BITS-1:0] pixel_in;

   modport source (output valid, opcode, first_of_group, pixel_in, input ready);
   modport sink   (input valid, opcode, first_of_group, pixel_in, output ready);
endinterface

interface prr_rsp_if #(parameter int PIXEL_BITS = 16);
   logic                         valid;
   logic                         ready;
   logic signed [PIXEL_BITS-1:0] pixel_out;
   logic                         saturated;

   modport source (output valid, pixel_out, saturated, input ready);
   modport sink   (input valid, pixel_out, saturated, output ready);
endinterface
`default_nettype wire

/* rtl/prr_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// prr_front
// Accepts input words, tracks the measured range and classifies apply words.
// ----------------------------------------------------------------------------
module prr_front
   import prr_pkg::*;
#(
   parameter int PIXEL_BITS = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   prr_req_if.sink                           req_chan,
   input  wire cfg_type                      cfg,
   input  wire logic                         full,
   output logic                              push,
   output cls_type                           push_cls,
   output logic signed [PIXEL_BITS-1:0]      push_pixel,
   output logic signed [PIXEL_BITS-1:0]      push_low,
   output logic signed [PIXEL_BITS-1:0]      push_high
);

   logic signed [PIXEL_BITS-1:0] low_ff, low_in;
   logic signed [PIXEL_BITS-1:0] high_ff, high_in;
   logic                         accept;
   logic signed [PIXEL_BITS-1:0] pix;
   logic                         pix_pos;

   assign req_chan.ready = !full;
   assign accept         = req_chan.valid && !full;
   assign pix            = req_chan.pixel_in;
   assign pix_pos        = !pix[PIXEL_BITS-1] && (pix != '0);

   always_comb begin
      low_in  = low_ff;
      high_in = high_ff;
      if (accept && (req_chan.opcode == OPC_MEASURE)) begin
         if (req_chan.first_of_group) begin
            low_in  = pix;
            high_in = pix;
         end else if (pix != '0) begin
            if (pix < low_ff) begin
               low_in = pix;
            end
            if (pix > high_ff) begin
               high_in = pix;
            end
         end
      end
   end

   always_comb begin
      if (cfg.mode == MODE_GAIN) begin
         push_cls = CLS_GAIN;
      end else if (!pix_pos) begin
         push_cls = CLS_ZERO;
      end else if (high_ff <= low_ff) begin
         push_cls = CLS_OMIN;
      end else begin
         push_cls = CLS_RANGE;
      end
   end

   assign push       = accept && (req_chan.opcode == OPC_APPLY);
   assign push_pixel = pix;
   assign push_low   = low_ff;
   assign push_high  = high_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff  <= '0;
         high_ff <= '0;
      end else begin
         low_ff  <= low_in;
         high_ff <= high_in;
      end
   end

endmodule
`default_nettype wire

/* rtl/prr_fifo.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// prr_fifo
// Short word queue between the front end and the back end.
// ----------------------------------------------------------------------------
module prr_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      rd_data,
   output logic                  full,
   output logic                  empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

/* rtl/prr_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// prr_back
// Computes one result per apply word: range map through an iterative
// divider, or gain multiply, then rounding and saturation into the
// result register.
// ----------------------------------------------------------------------------
module prr_back
   import prr_pkg::*;
#(
   parameter int PIXEL_BITS = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire cfg_type                      cfg,
   input  wire logic                         empty,
   output logic                              pop,
   input  wire cls_type                      cls,
   input  wire logic signed [PIXEL_BITS-1:0] pixel,
   input  wire logic signed [PIXEL_BITS-1:0] low,
   input  wire logic signed [PIXEL_BITS-1:0] high,
   prr_rsp_if.source                         rsp_chan
);

   localparam int P     = PIXEL_BITS;
   localparam int NUMW  = P + 18;            // signed numerator
   localparam int DW    = P + 18;            // 2|num| + den
   localparam int ITER  = (DW + 1) / 2;      // two quotient bits per cycle
   localparam int QW    = 2 * ITER;
   localparam int DVW   = P + 1;             // divisor 2*den
   localparam int CW    = $clog2(ITER + 1);
   localparam int PRODW = P + GAIN_BITS;
   localparam int OMW   = P + RANGE_BITS;
   localparam int SMW   = P + 17;
   localparam logic [QW-1:0] LIM_POS = {{(QW - P + 1){1'b0}}, {(P - 1){1'b1}}};
   localparam logic [QW-1:0] LIM_NEG = LIM_POS + 1'b1;

   typedef enum logic [7:0] {
      B_IDLE = 8'b0000_0001,
      B_GMUL = 8'b0000_0010,
      B_GRND = 8'b0000_0100,
      B_MUL1 = 8'b0000_1000,
      B_MUL2 = 8'b0001_0000,
      B_PREP = 8'b0010_0000,
      B_DIV  = 8'b0100_0000,
      B_OUT  = 8'b1000_0000
   } bst_type;

   bst_type               state_ff, state_in;
   logic [P-1:0]          den_ff, den_in;
   logic signed [P:0]     diff_ff, diff_in;
   logic [P-1:0]          pmag_ff, pmag_in;
   logic                  neg_ff, neg_in;
   logic [PRODW-1:0]      prod_ff, prod_in;
   logic signed [NUMW-1:0] acc_ff, acc_in;
   logic [QW-1:0]         quo_ff, quo_in;
   logic [DVW-1:0]        rem_ff, rem_in;
   logic [DVW-1:0]        dvs_ff, dvs_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [QW-1:0]         mag_ff, mag_in;
   logic                  out_valid_ff, out_valid_in;
   logic [P-1:0]          out_pix_ff, out_pix_in;
   logic                  out_sat_ff, out_sat_in;

   logic [OMW-1:0]        omul;
   logic signed [15:0]    span;
   logic signed [SMW-1:0] smul;
   logic [NUMW-1:0]       amag;
   logic [PRODW-1:0]      rsum;
   logic [QW-1:0]         step_q;
   logic [DVW-1:0]        step_r;
   logic                  load;
   logic [P-1:0]          sat_pix;
   logic                  sat_flag;

   assign omul = cfg.out_min * den_ff;
   assign span = $signed({1'b0, cfg.out_max}) - $signed({1'b0, cfg.out_min});
   assign smul = diff_ff * span;
   assign amag = acc_ff[NUMW-1] ? NUMW'(-acc_ff) : NUMW'(acc_ff);
   assign rsum = prod_ff + PRODW'(ROUND_HALF);

   // two restoring divide steps
   always_comb begin
      logic [DVW:0] t;
      step_r = rem_ff;
      step_q = quo_ff;
      for (int k = 0; k < 2; k++) begin
         t      = {step_r, step_q[QW-1]};
         step_q = {step_q[QW-2:0], 1'b0};
         if (t >= {1'b0, dvs_ff}) begin
            t         = t - {1'b0, dvs_ff};
            step_q[0] = 1'b1;
         end
         step_r = t[DVW-1:0];
      end
   end

   // sign and saturate the magnitude
   always_comb begin
      sat_flag = 1'b0;
      if (neg_ff) begin
         if (mag_ff > LIM_NEG) begin
            sat_flag = 1'b1;
            sat_pix  = {1'b1, {(P - 1){1'b0}}};
         end else begin
            sat_pix  = '0 - mag_ff[P-1:0];
         end
      end else begin
         if (mag_ff > LIM_POS) begin
            sat_flag = 1'b1;
            sat_pix  = {1'b0, {(P - 1){1'b1}}};
         end else begin
            sat_pix  = mag_ff[P-1:0];
         end
      end
   end

   assign load = (state_ff == B_OUT) && (!out_valid_ff || rsp_chan.ready);
   assign pop  = (state_ff == B_IDLE) && !empty;

   always_comb begin
      state_in = state_ff;
      den_in   = den_ff;
      diff_in  = diff_ff;
      pmag_in  = pmag_ff;
      neg_in   = neg_ff;
      prod_in  = prod_ff;
      acc_in   = acc_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      cnt_in   = cnt_ff;
      mag_in   = mag_ff;
      case (state_ff)
         B_IDLE: begin
            if (!empty) begin
               case (cls)
                  CLS_GAIN: begin
                     neg_in   = pixel[P-1];
                     pmag_in  = pixel[P-1] ? ('0 - pixel) : pixel;
                     state_in = B_GMUL;
                  end
                  CLS_OMIN: begin
                     neg_in   = 1'b0;
                     mag_in   = QW'(cfg.out_min);
                     state_in = B_OUT;
                  end
                  CLS_RANGE: begin
                     den_in   = P'(high - low);
                     diff_in  = (P+1)'(pixel) - (P+1)'(low);
                     state_in = B_MUL1;
                  end
                  default: begin
                     neg_in   = 1'b0;
                     mag_in   = '0;
                     state_in = B_OUT;
                  end
               endcase
            end
         end
         B_GMUL: begin
            prod_in  = pmag_ff * cfg.gain;
            state_in = B_GRND;
         end
         B_GRND: begin
            mag_in   = QW'(rsum >> FRAC_BITS);
            state_in = B_OUT;
         end
         B_MUL1: begin
            acc_in   = NUMW'(omul);
            state_in = B_MUL2;
         end
         B_MUL2: begin
            acc_in   = acc_ff + NUMW'(smul);
            state_in = B_PREP;
         end
         B_PREP: begin
            neg_in   = acc_ff[NUMW-1];
            quo_in   = QW'({amag[NUMW-2:0], 1'b0}) + QW'(den_ff);
            dvs_in   = {den_ff, 1'b0};
            rem_in   = '0;
            cnt_in   = '0;
            state_in = B_DIV;
         end
         B_DIV: begin
            quo_in = step_q;
            rem_in = step_r;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(ITER - 1)) begin
               mag_in   = step_q;
               state_in = B_OUT;
            end
         end
         B_OUT: begin
            if (load) begin
               state_in = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   // result register: holds a word while the next one is being computed
   assign out_valid_in = load || (out_valid_ff && !rsp_chan.ready);
   assign out_pix_in   = load ? sat_pix : out_pix_ff;
   assign out_sat_in   = load ? sat_flag : out_sat_ff;

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.pixel_out = out_pix_ff;
   assign rsp_chan.saturated = out_sat_ff;

   always_ff @(posedge clock) begin
      den_ff     <= den_in;
      diff_ff    <= diff_in;
      pmag_ff    <= pmag_in;
      neg_ff     <= neg_in;
      prod_ff    <= prod_in;
      acc_ff     <= acc_in;
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      dvs_ff     <= dvs_in;
      cnt_ff     <= cnt_in;
      mag_ff     <= mag_in;
      out_pix_ff <= out_pix_in;
      out_sat_ff <= out_sat_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_DIV) |-> (rem_ff < dvs_ff))
      else $error("divider remainder not below divisor");

   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      pop |-> (state_ff == B_IDLE) && !empty)
      else $error("queue popped while busy");

   a_div_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_DIV) |-> (cnt_ff < CW'(ITER)))
      else $error("divider ran past its step count");

   a_sat_at_limit: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_sat_ff) |->
         (out_pix_ff == {1'b0, {(P - 1){1'b1}}}) || (out_pix_ff == {1'b1, {(P - 1){1'b0}}}))
      else $error("saturated word not at a range limit");

endmodule
`default_nettype wire

/* rtl/pixel_range_rescaler.sv */
`default_nettype none
// Flow: measure words give no result. An apply word is queued and then taken by
//   the back end: a zero or empty range skips the arithmetic, gain mode
//   multiplies and rounds, and a range map multiplies twice, then divides.
// Throughput: one input word per cycle while the 2-entry queue has room; the back
//   end takes a new apply word only when idle, after the last result is loaded.
// Reset: synchronous; control and config registers take their reset values, range bounds clear.
// ----------------------------------------------------------------------------
// pixel_range_rescaler
// Min/max contrast stretch and Q16.16 gain with rounding and saturation.
// ----------------------------------------------------------------------------
module pixel_range_rescaler
   import prr_pkg::*;
#(
   parameter int PIXEL_BITS = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   prr_req_if.sink                       req_chan,
   prr_rsp_if.source                     rsp_chan,
   input  wire logic                     psel,
   input  wire logic                     penable,
   input  wire logic                     pwrite,
   input  wire logic [CFG_ADDR_BITS-1:0] paddr,
   input  wire logic [31:0]              pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);

   localparam int EW = CLS_BITS + 3 * PIXEL_BITS;

   cfg_type                      cfg_ff, cfg_in;
   logic                         wr_en;
   logic                         fifo_push;
   logic                         fifo_pop;
   logic                         fifo_full;
   logic                         fifo_empty;
   logic [EW-1:0]                fifo_wr;
   logic [EW-1:0]                fifo_rd;
   cls_type                      push_cls;
   logic signed [PIXEL_BITS-1:0] push_pixel;
   logic signed [PIXEL_BITS-1:0] push_low;
   logic signed [PIXEL_BITS-1:0] push_high;
   cls_type                      pop_cls;
   logic signed [PIXEL_BITS-1:0] pop_pixel;
   logic signed [PIXEL_BITS-1:0] pop_low;
   logic signed [PIXEL_BITS-1:0] pop_high;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (paddr[3:2])
            REG_MODE:    cfg_in.mode    = pwdata[0];
            REG_OUT_MIN: cfg_in.out_min = pwdata[RANGE_BITS-1:0];
            REG_OUT_MAX: cfg_in.out_max = pwdata[RANGE_BITS-1:0];
            REG_GAIN:    cfg_in.gain    = pwdata[GAIN_BITS-1:0];
            default:     cfg_in         = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_MODE:    prdata = 32'(cfg_ff.mode);
         REG_OUT_MIN: prdata = 32'(cfg_ff.out_min);
         REG_OUT_MAX: prdata = 32'(cfg_ff.out_max);
         REG_GAIN:    prdata = cfg_ff.gain;
         default:     prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode    <= MODE_RANGE;
         cfg_ff.out_min <= OUT_MIN_RST;
         cfg_ff.out_max <= OUT_MAX_RST;
         cfg_ff.gain    <= GAIN_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   prr_front #(
      .PIXEL_BITS (PIXEL_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .cfg        (cfg_ff),
      .full       (fifo_full),
      .push       (fifo_push),
      .push_cls   (push_cls),
      .push_pixel (push_pixel),
      .push_low   (push_low),
      .push_high  (push_high)
   );

   assign fifo_wr = {push_cls, push_pixel, push_low, push_high};

   prr_fifo #(
      .WIDTH (EW),
      .DEPTH (2)
   ) u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (fifo_push),
      .wr_data (fifo_wr),
      .pop     (fifo_pop),
      .rd_data (fifo_rd),
      .full    (fifo_full),
      .empty   (fifo_empty)
   );

   assign pop_cls   = cls_type'(fifo_rd[EW-1 -: CLS_BITS]);
   assign pop_pixel = fifo_rd[3*PIXEL_BITS-1 -: PIXEL_BITS];
   assign pop_low   = fifo_rd[2*PIXEL_BITS-1 -: PIXEL_BITS];
   assign pop_high  = fifo_rd[PIXEL_BITS-1:0];

   prr_back #(
      .PIXEL_BITS (PIXEL_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .empty    (fifo_empty),
      .pop      (fifo_pop),
      .cls      (pop_cls),
      .pixel    (pop_pixel),
      .low      (pop_low),
      .high     (pop_high),
      .rsp_chan (rsp_chan)
   );

endmodule
`default_nettype wire

/* verif/pixel_range_rescaler_tb.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pixel_range_rescaler_tb
// Self-checking bench for the rescaler. Input words go through a queue into a
// valid/ready driver. Each accepted word updates a shadow of the measured
// bounds, and apply words push the expected pixel. A monitor compares every
// result word with the oldest expected one. Registers are rewritten between
// phases once the block has drained.
// ----------------------------------------------------------------------------
module pixel_range_rescaler_tb;
   import prr_pkg::*;

   localparam int     PIXEL_BITS    = 16;
   localparam int     PERIOD        = 10;
   localparam int     RESET_CYCLES  = 9;
   localparam int     SETTLE_CYCLES = 30;     // longer than a range map
   localparam int     HOLD_CYCLES   = 400;
   localparam int     STALL_LIMIT   = 3000;
   localparam int     PHASES        = 9;
   localparam int     PHASE_WORDS   = 75;
   localparam longint PIX_HI        = 32767;
   localparam longint PIX_LO        = -32768;
   localparam logic signed [PIXEL_BITS-1:0] PIX_MAX16 = 16'sh7fff;
   localparam logic signed [PIXEL_BITS-1:0] PIX_MIN16 = 16'sh8000;

   typedef struct packed {
      logic                         opcode;
      logic                         first_of_group;
      logic signed [PIXEL_BITS-1:0] pixel_in;
   } pix_word_type;

   typedef struct packed {
      logic signed [PIXEL_BITS-1:0] pixel_out;
      logic                         saturated;
   } pix_result_type;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     psel;
   logic                     penable;
   logic                     pwrite;
   logic [CFG_ADDR_BITS-1:0] paddr;
   logic [31:0]              pwdata;
   logic [31:0]              prdata;
   logic                     pready;

   prr_req_if #(.PIXEL_BITS(PIXEL_BITS)) req_if ();
   prr_rsp_if #(.PIXEL_BITS(PIXEL_BITS)) rsp_if ();

   pixel_range_rescaler #(.PIXEL_BITS(PIXEL_BITS)) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   always #(PERIOD/2) clock = ~clock;

   // shadow of the block
   cfg_type                      shadow_cfg;
   logic signed [PIXEL_BITS-1:0] bound_low;
   logic signed [PIXEL_BITS-1:0] bound_high;

   pix_word_type   pending_words[$];
   pix_result_type due_results[$];

   int   fail_count   = 0;
   int   result_index = 0;
   int   queued_count = 0;
   int   send_gap     = 0;
   int   recv_gap     = 0;
   int   hold_count   = 0;
   int   idle_cycles  = 0;
   logic steady       = 1'b0;
   logic hold_phase   = 1'b0;
   logic hold_over    = 1'b0;

   task automatic report_mismatch(string what);
      $display("mismatch at %0t: %s", $time, what);
      fail_count++;
   endtask

   // mostly back to back or short gaps, now and then a long one; none while steady
   function automatic int next_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady) return 0;
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // bound tracking and the expected pixel of an apply word
   function automatic void track_word(pix_word_type w);
      logic signed [PIXEL_BITS-1:0] pix;
      longint                       p, lo, hi, omin, den, span, num, mag, q, res;
      longint unsigned              m, r;
      pix_result_type               want;
      pix = w.pixel_in;
      p   = longint'(pix);
      if (w.opcode == OPC_MEASURE) begin
         if (w.first_of_group) begin
            bound_low  = pix;
            bound_high = pix;
         end else if (pix != 0) begin
            if (pix < bound_low)  bound_low  = pix;
            if (pix > bound_high) bound_high = pix;
         end
         return;
      end
      res = 0;
      if (shadow_cfg.mode == MODE_RANGE) begin
         if (p > 0) begin
            lo   = longint'(bound_low);
            hi   = longint'(bound_high);
            omin = longint'(shadow_cfg.out_min);
            if (hi <= lo) begin
               res = omin;
            end else begin
               den  = hi - lo;
               span = longint'(shadow_cfg.out_max) - omin;
               num  = omin * den + (p - lo) * span;
               mag  = (num < 0) ? -num : num;
               q    = (2 * mag + den) / (2 * den);
               res  = (num < 0) ? -q : q;
            end
         end
      end else begin
         m   = (p < 0) ? -p : p;
         r   = (m * shadow_cfg.gain + 64'h8000) >> FRAC_BITS;
         res = (p < 0) ? -longint'(r) : longint'(r);
      end
      want.saturated = 1'b0;
      if (res > PIX_HI) begin
         res            = PIX_HI;
         want.saturated = 1'b1;
      end else if (res < PIX_LO) begin
         res            = PIX_LO;
         want.saturated = 1'b1;
      end
      want.pixel_out = res[PIXEL_BITS-1:0];
      due_results.push_back(want);
   endfunction

   function automatic void offer(logic op, logic first, logic signed [PIXEL_BITS-1:0] pix);
      pending_words.push_back('{op, first, pix});
      queued_count++;
   endfunction

   function automatic logic signed [PIXEL_BITS-1:0] draw_pixel();
      logic signed [PIXEL_BITS-1:0] v;
      v = PIXEL_BITS'($urandom());
      case ($urandom_range(0, 9))
         0:       v = PIX_MIN16;
         1:       v = PIX_MAX16;
         2:       v = '0;
         3:       v = $signed(16'($urandom_range(0, 20))) - 16'sd10;
         4:       v = 16'($urandom_range(1, 300));
         default: ;
      endcase
      return v;
   endfunction

   // a measured group followed by apply words, or a short burst of noise
   function automatic void queue_group();
      int n;
      if ($urandom_range(0, 9) < 8) begin
         offer(OPC_MEASURE, 1'b1, draw_pixel());
         n = $urandom_range(0, 6);
         repeat (n) offer(OPC_MEASURE, 1'b0, draw_pixel());
         n = $urandom_range(1, 6);
         repeat (n) offer(OPC_APPLY, 1'($urandom_range(0, 1)), draw_pixel());
      end else begin
         n = $urandom_range(1, 4);
         repeat (n) offer(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), draw_pixel());
      end
   endfunction

   task automatic csr_write(input logic [1:0] index, input logic [31:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= {index, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (index)
         REG_MODE:    shadow_cfg.mode    = value[0];
         REG_OUT_MIN: shadow_cfg.out_min = value[RANGE_BITS-1:0];
         REG_OUT_MAX: shadow_cfg.out_max = value[RANGE_BITS-1:0];
         REG_GAIN:    shadow_cfg.gain    = value[GAIN_BITS-1:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic apply_setting(int k);
      logic [RANGE_BITS-1:0] a, b;
      logic [GAIN_BITS-1:0]  g;
      a = RANGE_BITS'($urandom());
      b = RANGE_BITS'($urandom());
      case ($urandom_range(0, 5))
         0:       begin a = '0; b = '1; end
         1:       b = a;
         2:       begin a = '1; b = '0; end
         default: if (a > b) {a, b} = {b, a};
      endcase
      case ($urandom_range(0, 5))
         0:       g = GAIN_RST;
         1:       g = '1;
         2:       g = '0;
         3:       g = $urandom_range(0, 4 * 65536);
         default: g = $urandom();
      endcase
      csr_write(REG_MODE, {31'd0, (k % 3 == 1) ? MODE_GAIN : MODE_RANGE});
      csr_write(REG_OUT_MIN, {17'd0, a});
      csr_write(REG_OUT_MAX, {17'd0, b});
      csr_write(REG_GAIN, g);
   endtask

   // wait until every word is in and every result is out, then let it settle
   task automatic drain();
      do @(negedge clock);
      while (pending_words.size() != 0 || req_if.valid || due_results.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   always @(posedge clock) begin : word_driver
      pix_word_type w;
      if (reset) begin
         req_if.valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            w = '{req_if.opcode, req_if.first_of_group, req_if.pixel_in};
            track_word(w);
            send_gap = next_gap();
         end
         if (!req_if.valid || req_if.ready) begin
            if (send_gap == 0 && pending_words.size() != 0) begin
               w = pending_words.pop_front();
               req_if.opcode         <= w.opcode;
               req_if.first_of_group <= w.first_of_group;
               req_if.pixel_in       <= w.pixel_in;
               req_if.valid          <= 1'b1;
            end else begin
               if (send_gap != 0) send_gap--;
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off, counted here
   always @(posedge clock) begin
      if (hold_phase && !hold_over) begin
         if (hold_count == HOLD_CYCLES) hold_over <= 1'b1;
         hold_count <= hold_count + 1;
      end
   end

   always @(posedge clock) begin : result_ready
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (hold_phase && !hold_over) begin
         rsp_if.ready <= 1'b0;
      end else if (recv_gap != 0) begin
         recv_gap--;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
         if ($urandom_range(0, 5) == 0) recv_gap = next_gap();
      end
   end

   always @(posedge clock) begin : result_check
      pix_result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (due_results.size() == 0) begin
            report_mismatch($sformatf("result word %0d arrived with none expected",
                                      result_index));
         end else begin
            want = due_results.pop_front();
            if (rsp_if.pixel_out !== want.pixel_out)
               report_mismatch($sformatf("result word %0d pixel_out %0d, expected %0d",
                                         result_index, rsp_if.pixel_out, want.pixel_out));
            if (rsp_if.saturated !== want.saturated)
               report_mismatch($sformatf("result word %0d saturated %0b, expected %0b",
                                         result_index, rsp_if.saturated, want.saturated));
         end
         result_index++;
      end
   end

   initial begin : watchdog
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
             || psel)
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("pixel_range_rescaler_tb: FAIL");
      $finish;
   end

   initial begin : stimulus
      reset                 = 1'b1;
      req_if.valid          = 1'b0;
      req_if.opcode         = OPC_MEASURE;
      req_if.first_of_group = 1'b0;
      req_if.pixel_in       = '0;
      rsp_if.ready          = 1'b0;
      psel                  = 1'b0;
      penable               = 1'b0;
      pwrite                = 1'b0;
      paddr                 = '0;
      pwdata                = '0;
      shadow_cfg.mode       = MODE_RANGE;
      shadow_cfg.out_min    = OUT_MIN_RST;
      shadow_cfg.out_max    = OUT_MAX_RST;
      shadow_cfg.gain       = GAIN_RST;
      bound_low             = '0;
      bound_high            = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // range mode with reset registers
      offer(OPC_APPLY,   1'b0, 16'sd100);     // bounds still at reset
      offer(OPC_MEASURE, 1'b1, 16'sd0);       // seed from a zero pixel
      offer(OPC_MEASURE, 1'b0, 16'sd0);       // ignored
      offer(OPC_MEASURE, 1'b0, 16'sd1000);
      offer(OPC_MEASURE, 1'b0, 16'sd50);
      offer(OPC_APPLY,   1'b0, 16'sd500);     // tie rounds up
      offer(OPC_APPLY,   1'b1, 16'sd1000);    // first bit ignored on apply
      offer(OPC_APPLY,   1'b0, PIX_MAX16);    // extrapolated, clipped
      offer(OPC_APPLY,   1'b0, 16'sd0);
      offer(OPC_APPLY,   1'b0, PIX_MIN16);
      offer(OPC_MEASURE, 1'b1, 16'sd7);
      offer(OPC_APPLY,   1'b0, 16'sd7);       // equal bounds
      offer(OPC_MEASURE, 1'b1, PIX_MAX16);
      offer(OPC_MEASURE, 1'b0, PIX_MIN16);
      offer(OPC_APPLY,   1'b0, PIX_MAX16);
      offer(OPC_APPLY,   1'b0, 16'sd1);
      offer(OPC_MEASURE, 1'b1, 16'sd500);
      offer(OPC_MEASURE, 1'b0, 16'sd100);
      drain();

      // inverted output span: clips high and low
      csr_write(REG_OUT_MIN, 32'd32767);
      csr_write(REG_OUT_MAX, 32'd0);
      offer(OPC_APPLY, 1'b0, 16'sd50);
      offer(OPC_APPLY, 1'b0, PIX_MAX16);
      drain();

      // gain mode: half gain ties, measure word gives nothing, gain extremes
      csr_write(REG_MODE, {31'd0, MODE_GAIN});
      csr_write(REG_GAIN, 32'h0000_8000);
      offer(OPC_APPLY,   1'b0, 16'sd1);
      offer(OPC_APPLY,   1'b0, -16'sd1);
      offer(OPC_MEASURE, 1'b0, 16'sd5);
      drain();
      csr_write(REG_GAIN, 32'hffff_ffff);
      offer(OPC_APPLY, 1'b0, PIX_MIN16);
      drain();
      csr_write(REG_GAIN, 32'h0000_0000);
      offer(OPC_APPLY, 1'b0, PIX_MAX16);
      drain();
      csr_write(REG_GAIN, GAIN_RST);
      offer(OPC_APPLY, 1'b0, PIX_MIN16);
      drain();

      for (int k = 0; k < PHASES; k++) begin
         apply_setting(k);
         steady = (k == 3);
         if (k == 5) hold_phase = 1'b1;   // receiver holds off, block backs up
         queued_count = 0;
         while (queued_count < PHASE_WORDS) queue_group();
         drain();
      end
      steady = 1'b0;

      if (fail_count == 0)
         $display("pixel_range_rescaler_tb: PASS");
      else
         $display("pixel_range_rescaler_tb: FAIL");
      $finish;
   end

endmodule
`default_nettype wire

/* sim.f */
rtl/prr_pkg.sv
rtl/prr_if.sv
rtl/prr_front.sv
rtl/prr_fifo.sv
rtl/prr_back.sv
rtl/pixel_range_rescaler.sv
verif/pixel_range_rescaler_tb.sv
